// ===== rtl/core/b32c_pkg.sv =====
// Shared types, constants and helper functions for the base32 stream codec.
`timescale 1ns / 1ps

package b32c_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_DIGIT_2 = 8'h32;
    localparam logic [7:0] ASCII_DIGIT_7 = 8'h37;
    localparam logic [4:0] LETTER_COUNT  = 5'd26;

    // One result as it leaves the block.
    typedef struct packed {
        logic [7:0] out_value;
        logic       value_valid;
        logic       error;
        logic       end_of_message;
    } result_t;

    // All results caused by one input item, oldest in slot 0.
    typedef struct packed {
        logic [1:0]       count;
        result_t [2:0]    res;
    } job_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] sym_char(input logic [4:0] s);
        logic [7:0] c;
        if (s < LETTER_COUNT)
            c = ASCII_LOWER_A + {3'b000, s};
        else
            c = ASCII_DIGIT_2 + {3'b000, s - LETTER_COUNT};
        return c;
    endfunction

    // Returns {valid, code}.
    function automatic logic [5:0] char_code(input logic [7:0] c);
        logic [5:0] r;
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
            r = {1'b1, 5'(c - ASCII_LOWER_A)};
        else if (c >= ASCII_DIGIT_2 && c <= ASCII_DIGIT_7)
            r = {1'b1, 5'(c - ASCII_DIGIT_2) + LETTER_COUNT};
        else
            r = 6'd0;
        return r;
    endfunction

endpackage

// ===== rtl/core/b32c_queue.sv =====
// Short job queue between the front and back of the base32 codec.
`timescale 1ns / 1ps

module b32c_queue
    import b32c_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head_job,
    output queue_status_t status
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] fill_reg;
    logic [QUEUE_CW-1:0] fill_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full))
        else $error("push into full job queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("pop from empty job queue");

endmodule

// ===== rtl/core/b32c_front.sv =====
// Front end: takes items and the mode register, tracks bit state, builds result jobs.
`timescale 1ns / 1ps

module b32c_front
    import b32c_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_mode,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    value,
    input  logic          last,
    input  queue_status_t status,
    output logic          push,
    output job_t          push_job
);

    logic       mode_reg;
    logic [6:0] bit_buffer_reg;
    logic [6:0] bit_buffer_next;
    logic [2:0] bit_count_reg;
    logic [2:0] bit_count_next;
    logic       error_skip_reg;
    logic       error_skip_next;

    logic        accept;
    job_t        job;
    logic [11:0] ebuf;
    logic [3:0]  ecnt;
    logic [3:0]  erem;
    logic [4:0]  s0;
    logic [4:0]  s1;
    logic [4:0]  pad;
    logic [11:0] emask;
    logic [5:0]  code;
    logic [11:0] dbuf;
    logic [3:0]  dcnt;
    logic [3:0]  drem;
    logic [11:0] dmask;
    logic [11:0] dnew;
    logic [1:0]  n;

    assign cfg_ready = 1'b1;
    assign in_ready  = !status.full;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        job             = '0;
        n               = 2'd0;
        bit_buffer_next = bit_buffer_reg;
        bit_count_next  = bit_count_reg;
        error_skip_next = error_skip_reg;

        // Encode path: append the byte, peel off five bits at a time.
        ebuf  = {bit_buffer_reg[3:0], value};
        ecnt  = {1'b0, bit_count_reg} + 4'd8;
        s0    = 5'(ebuf >> (ecnt - 4'd5));
        s1    = 5'(ebuf >> (ecnt - 4'd10));
        erem  = (ecnt >= 4'd10) ? ecnt - 4'd10 : ecnt - 4'd5;
        pad   = 5'(ebuf << (4'd5 - erem));
        emask = (12'd1 << erem) - 12'd1;

        // Decode path: append five bits, emit a byte once eight are held.
        code  = char_code(value);
        dbuf  = {bit_buffer_reg, code[4:0]};
        dcnt  = {1'b0, bit_count_reg} + 4'd5;
        drem  = (dcnt >= 4'd8) ? dcnt - 4'd8 : dcnt;
        dmask = (12'd1 << drem) - 12'd1;
        dnew  = dbuf & dmask;

        if (mode_reg == MODE_ENCODE)
        begin
            job.res[0] = '{out_value: sym_char(s0), value_valid: 1'b1,
                           error: 1'b0, end_of_message: 1'b0};
            n = 2'd1;
            if (ecnt >= 4'd10)
            begin
                job.res[1] = '{out_value: sym_char(s1), value_valid: 1'b1,
                               error: 1'b0, end_of_message: 1'b0};
                n = 2'd2;
            end
            if (last)
            begin
                if (erem != 4'd0)
                begin
                    job.res[n] = '{out_value: sym_char(pad), value_valid: 1'b1,
                                   error: 1'b0, end_of_message: 1'b1};
                    n = n + 2'd1;
                end
                else
                    job.res[n - 2'd1].end_of_message = 1'b1;
                bit_buffer_next = '0;
                bit_count_next  = '0;
                error_skip_next = 1'b0;
            end
            else
            begin
                bit_buffer_next = 7'(ebuf & emask);
                bit_count_next  = 3'(erem);
            end
        end
        else if (error_skip_reg)
        begin
            if (last)
            begin
                job.res[0] = '{out_value: 8'd0, value_valid: 1'b0,
                               error: 1'b1, end_of_message: 1'b1};
                n = 2'd1;
                bit_buffer_next = '0;
                bit_count_next  = '0;
                error_skip_next = 1'b0;
            end
        end
        else if (!code[5])
        begin
            job.res[0] = '{out_value: 8'd0, value_valid: 1'b0,
                           error: 1'b1, end_of_message: last};
            n = 2'd1;
            bit_buffer_next = '0;
            bit_count_next  = '0;
            error_skip_next = !last;
        end
        else
        begin
            if (dcnt >= 4'd8)
            begin
                job.res[0] = '{out_value: 8'(dbuf >> (dcnt - 4'd8)), value_valid: 1'b1,
                               error: 1'b0, end_of_message: 1'b0};
                n = 2'd1;
            end
            if (last)
            begin
                if (drem != 4'd0 && dnew != 12'd0)
                begin
                    job.res[n] = '{out_value: 8'd0, value_valid: 1'b0,
                                   error: 1'b1, end_of_message: 1'b1};
                    n = n + 2'd1;
                end
                else if (n != 2'd0)
                    job.res[0].end_of_message = 1'b1;
                else
                begin
                    job.res[0] = '{out_value: 8'd0, value_valid: 1'b0,
                                   error: 1'b0, end_of_message: 1'b1};
                    n = 2'd1;
                end
                bit_buffer_next = '0;
                bit_count_next  = '0;
                error_skip_next = 1'b0;
            end
            else
            begin
                bit_buffer_next = 7'(dnew);
                bit_count_next  = 3'(drem);
            end
        end
        job.count = n;
    end

    assign push     = accept && (job.count != 2'd0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_ENCODE;
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            error_skip_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg       <= cfg_mode;
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            error_skip_reg <= 1'b0;
        end
        else if (accept)
        begin
            bit_buffer_reg <= bit_buffer_next;
            bit_count_reg  <= bit_count_next;
            error_skip_reg <= error_skip_next;
        end
    end

    a_push_nonempty_job: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_job.count != 2'd0) && (push_job.count != 2'd3 || mode_reg == MODE_ENCODE))
        else $error("job pushed with bad result count");

endmodule

// ===== rtl/core/b32c_back.sv =====
// Back end: walks the head job into the output register, one result per cycle unless stalled.
`timescale 1ns / 1ps

module b32c_back
    import b32c_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  job_t          head_job,
    input  queue_status_t status,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_value,
    output logic          value_valid,
    output logic          error,
    output logic          end_of_message
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;
    logic       load;
    logic       take;
    logic       job_done;

    assign load     = !out_valid_reg || out_ready;
    assign take     = load && !status.empty;
    assign job_done = (idx_reg == head_job.count - 2'd1);
    assign pop      = take && job_done;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = job_done ? 2'd0 : idx_reg + 2'd1;
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = !status.empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= head_job.res[idx_reg];
    end

    assign out_valid      = out_valid_reg;
    assign out_value      = out_reg.out_value;
    assign value_valid    = out_reg.value_valid;
    assign error          = out_reg.error;
    assign end_of_message = out_reg.end_of_message;

    a_idx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> (idx_reg == 2'd0))
        else $error("result index left nonzero with no job pending");

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        !status.empty |-> (idx_reg < head_job.count))
        else $error("result index beyond the head job");

endmodule

// ===== rtl/core/base32_stream_codec_core.sv =====
// Top level of the base32 stream codec: front end, job queue and back end.
// An item's job is registered in the queue, then its results in the output register.
// Throughput: one item per cycle in while the job queue has room, one result per cycle out
// while out_ready allows; long encode messages give eight characters for every five bytes.
// The four-entry job queue and the output register set these rates.
// Reset (rst_n low, asynchronous) selects encode mode and clears bit state, queue and output.
`timescale 1ns / 1ps

module base32_stream_codec_core
    import b32c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] value,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_value,
    output logic       value_valid,
    output logic       error,
    output logic       end_of_message
);

    // Jobs carry every result of one item; items that make no result (decode characters
    // skipped after an error or not yet completing a byte) never enter the queue.
    job_t          push_job;
    job_t          head_job;
    logic          push;
    logic          pop;
    queue_status_t status;

    // Front: hold mode and bit state, classify each item, build its job.
    b32c_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_mode (cfg_mode),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .last     (last),
        .status   (status),
        .push     (push),
        .push_job (push_job)
    );

    // Queue: decouple item intake from result delivery.
    b32c_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head_job(head_job),
        .status  (status)
    );

    // Back: advance through the head job, one result per output handshake.
    b32c_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .status        (status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_value     (out_value),
        .value_valid   (value_valid),
        .error         (error),
        .end_of_message(end_of_message)
    );

endmodule

// ===== bench/b32c_stream_checker.sv =====
// Channel monitor for the base32 stream codec: predicts every result and compares it.
`timescale 1ns / 1ps

module b32c_stream_checker
    import b32c_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_mode,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] value,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_value,
    input  logic       value_valid,
    input  logic       error,
    input  logic       end_of_message,
    output int         mismatch_count,
    output int         pending_results
);

    localparam logic [255:0] ALPHABET = "abcdefghijklmnopqrstuvwxyz234567";

    result_t     awaited_results [$];
    logic        codec_mode;
    logic [11:0] held_bits;
    int          held_count;
    logic        skipping;
    int          mismatches;

    function automatic logic [15:0] low_bits(input logic [15:0] x, input int n);
        return x & ((16'd1 << n) - 16'd1);
    endfunction

    function automatic result_t make_result(input logic [7:0] v, input logic vv,
                                            input logic e, input logic m);
        result_t r;
        r.out_value      = v;
        r.value_valid    = vv;
        r.error          = e;
        r.end_of_message = m;
        return r;
    endfunction

    // Map an ASCII character to its 5-bit code, -1 if it is not in the alphabet.
    function automatic int symbol_code(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
            return int'(c) - 'h61;
        if (c >= 8'h32 && c <= 8'h37)
            return int'(c) - 'h32 + 26;
        return -1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic clear_message();
        held_bits  = '0;
        held_count = 0;
        skipping   = 1'b0;
    endtask

    // Advance the codec state by one accepted item and queue the results it causes.
    task automatic convert_item(input logic [7:0] v, input logic l);
        result_t     res [3];
        int          n;
        int          cnt;
        int          code;
        logic [15:0] acc;
        logic [4:0]  sym;
        n = 0;
        if (codec_mode == MODE_ENCODE) begin
            acc = (low_bits(16'(held_bits), held_count) << 8) | 16'(v);
            cnt = held_count + 8;
            while (cnt >= 5) begin
                sym = 5'(acc >> (cnt - 5));
                cnt -= 5;
                res[n] = make_result(ALPHABET[255 - 8 * sym -: 8], 1'b1, 1'b0, 1'b0);
                n++;
            end
            if (l) begin
                if (cnt > 0) begin
                    sym = 5'(acc << (5 - cnt));
                    res[n] = make_result(ALPHABET[255 - 8 * sym -: 8], 1'b1, 1'b0, 1'b1);
                    n++;
                end else begin
                    res[n - 1].end_of_message = 1'b1;
                end
                clear_message();
            end else begin
                held_count = cnt;
                held_bits  = 12'(low_bits(acc, cnt));
            end
        end else if (skipping) begin
            if (l) begin
                res[0] = make_result(8'h00, 1'b0, 1'b1, 1'b1);
                n = 1;
                clear_message();
            end
        end else begin
            code = symbol_code(v);
            if (code < 0) begin
                res[0] = make_result(8'h00, 1'b0, 1'b1, l);
                n = 1;
                clear_message();
                skipping = !l;
            end else begin
                acc = (low_bits(16'(held_bits), held_count) << 5) | 16'(code);
                cnt = held_count + 5;
                if (cnt >= 8) begin
                    res[n] = make_result(8'(acc >> (cnt - 8)), 1'b1, 1'b0, 1'b0);
                    n++;
                    cnt -= 8;
                end
                acc = low_bits(acc, cnt);
                if (l) begin
                    if (cnt > 0 && acc != 16'd0) begin
                        res[n] = make_result(8'h00, 1'b0, 1'b1, 1'b1);
                        n++;
                    end else if (n > 0) begin
                        res[n - 1].end_of_message = 1'b1;
                    end else begin
                        res[n] = make_result(8'h00, 1'b0, 1'b0, 1'b1);
                        n++;
                    end
                    clear_message();
                end else begin
                    held_bits  = 12'(acc);
                    held_count = cnt;
                end
            end
        end
        for (int k = 0; k < n; k++)
            awaited_results = {awaited_results, res[k]};
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t seen;
        result_t want;
        if (!rst_n) begin
            awaited_results.delete();
            codec_mode = MODE_ENCODE;
            clear_message();
            mismatches = 0;
            mismatch_count  <= 0;
            pending_results <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                codec_mode = cfg_mode;
                clear_message();
            end
            if (out_valid && out_ready) begin
                seen = make_result(out_value, value_valid, error, end_of_message);
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %02h vv %0b err %0b eom %0b",
                                              seen.out_value, seen.value_valid, seen.error,
                                              seen.end_of_message));
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.out_value !== want.out_value
                        || seen.value_valid !== want.value_valid
                        || seen.error !== want.error
                        || seen.end_of_message !== want.end_of_message)
                        report_mismatch($sformatf(
                            "got %02h/%0b/%0b/%0b want %02h/%0b/%0b/%0b (value/vv/err/eom)",
                            seen.out_value, seen.value_valid, seen.error, seen.end_of_message,
                            want.out_value, want.value_valid, want.error,
                            want.end_of_message));
                end
            end
            if (in_valid && in_ready)
                convert_item(value, last);
            mismatch_count  <= mismatches;
            pending_results <= awaited_results.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the base32 stream codec bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    import b32c_pkg::*;

    // Cycles to let pass after the last awaited result before touching the
    // mode register: items in a skipped message cause no result and may
    // still be inside the block.
    localparam int SETTLE_CYCLES = 8;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_mode  = MODE_ENCODE;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] value     = 8'h00;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_value;
    logic       value_valid;
    logic       error;
    logic       end_of_message;

    int         mismatch_count;
    int         pending_results;

    // Sender burst bookkeeping.
    int         burst_left = 0;

    // Receiver stall pattern: a style held for a random stretch of cycles.
    int         stall_style = 0;
    int         stall_left  = 0;

    always #5 clk = ~clk;

    base32_stream_codec_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_mode       (cfg_mode),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .value          (value),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_value      (out_value),
        .value_valid    (value_valid),
        .error          (error),
        .end_of_message (end_of_message)
    );

    b32c_stream_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_mode        (cfg_mode),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .value           (value),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_value       (out_value),
        .value_valid     (value_valid),
        .error           (error),
        .end_of_message  (end_of_message),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Receiver: hold one of three styles (always ready, coin flip, mostly
    // stalled) until its countdown runs out, then pick again. The always-ready style
    // gives stretches with no back-pressure at all.
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 2);
            stall_left  <= $urandom_range(20, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Present one item and hold it until accepted. Valid is left high: the
    // caller either presents the next item in the same step or drops valid.
    task automatic send_item(input logic [7:0] v, input logic l);
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Send with bursts: after each burst, drop valid for a random gap unless the gap drawn is zero.
    task automatic paced_send(input logic [7:0] v, input logic l);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 32)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_item(v, l);
    endtask

    // Drop valid and wait until every awaited result has arrived, then idle
    // for settle_cycles more. The first step lets the checker count an item
    // accepted at the current edge.
    task automatic wait_drained(input int settle_cycles);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_valid <= 1'b1;
        cfg_mode  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random messages in the current mode. Decode messages are mostly
    // well-formed: the final character has its leftover bits zeroed where
    // they all fall inside it. The rest carry one noise byte or are pure noise.
    task automatic run_random_phase(input logic m, input int item_goal, input bit hold_midway);
        logic [7:0] msg [$];
        logic [4:0] keep;
        int         sent;
        int         len;
        int         code;
        int         leftover;
        int         kind;
        bit         held;
        sent = 0;
        held = 1'b0;
        while (sent < item_goal) begin
            msg.delete();
            if (m == MODE_ENCODE) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 9);
                repeat (len) msg = {msg, 8'($urandom_range(0, 255))};
            end else begin
                kind = $urandom_range(0, 9);
                len  = $urandom_range(1, 16);
                for (int k = 0; k < len; k++) begin
                    code = $urandom_range(0, 31);
                    if (k == len - 1) begin
                        leftover = (5 * len) % 8;
                        keep     = 5'h1F << (leftover > 5 ? 5 : leftover);
                        code     = code & int'(keep);
                    end
                    msg = {msg, code < LETTER_COUNT ? 8'(ASCII_LOWER_A + code)
                                                    : 8'(ASCII_DIGIT_2 + code - LETTER_COUNT)};
                end
                if (kind == 7 || kind == 8) begin
                    msg[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
                end else if (kind == 9) begin
                    foreach (msg[k])
                        msg[k] = 8'($urandom_range(0, 255));
                end
            end
            foreach (msg[k])
                paced_send(msg[k], k == msg.size() - 1);
            sent += msg.size();
            // Hold the sender once until the output side has fully caught up.
            if (hold_midway && !held && sent >= item_goal / 2) begin
                wait_drained(0);
                held = 1'b1;
            end
        end
        // Leave a message open so the next mode write has to discard it.
        repeat ($urandom_range(1, 3)) begin
            code = $urandom_range(0, 31);
            if (m == MODE_ENCODE)
                paced_send(8'($urandom_range(0, 255)), 1'b0);
            else
                paced_send(code < LETTER_COUNT ? 8'(ASCII_LOWER_A + code)
                                               : 8'(ASCII_DIGIT_2 + code - LETTER_COUNT),
                           1'b0);
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed encode: a lone zero byte and a lone all-ones byte (each
        // ends on a padded character), then a 40-bit message whose final
        // character comes out with no padding.
        write_mode(MODE_ENCODE);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item(8'hFF, 1'b1);
        wait_drained(SETTLE_CYCLES);

        // Directed decode: alphabet edges, nonzero remainder after a byte,
        // single character with nonzero bits, bare end marker, invalid
        // character mid-message followed by skipped items, invalid
        // character on the final item, and values just outside each range.
        write_mode(MODE_DECODE);
        send_item("a", 1'b0);
        send_item("z", 1'b1);
        send_item("2", 1'b0);
        send_item("7", 1'b1);
        send_item("q", 1'b1);
        send_item("a", 1'b1);
        send_item("b", 1'b0);
        send_item(8'h60, 1'b0);
        send_item("c", 1'b0);
        send_item("d", 1'b1);
        send_item(8'h7B, 1'b1);
        send_item(8'h31, 1'b0);
        send_item(8'h38, 1'b1);
        wait_drained(SETTLE_CYCLES);

        // Random phases, alternating mode; one of them pauses midway.
        for (int phase = 0; phase < 6; phase++) begin
            write_mode(phase % 2 == 0 ? MODE_ENCODE : MODE_DECODE);
            run_random_phase(phase % 2 == 0 ? MODE_ENCODE : MODE_DECODE, 62, phase == 3);
            wait_drained(SETTLE_CYCLES);
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/b32c_pkg.sv
rtl/core/b32c_queue.sv
rtl/core/b32c_front.sv
rtl/core/b32c_back.sv
rtl/core/base32_stream_codec_core.sv
bench/b32c_stream_checker.sv
bench/testbench.sv
